FILE: rtl/dcmq_pkg.sv
package dcmq_pkg;

  localparam int WORD     = 32;
  localparam int WIDE     = 62;   // scaled radicand and dividend width
  localparam int RAD_W    = 33;   // positive radicand stays below 2^33
  localparam int MAG_W    = 33;   // off-diagonal sum magnitude, up to 2^32
  localparam int ROOT_W   = 31;   // pivot component width
  localparam int SQ_STEPS = 31;   // one root bit per stage
  localparam int DV_STEPS = 31;   // one quotient bit per stage
  localparam int QDEPTH   = 2;

  localparam logic [WORD-1:0] SAT_MAX = 32'h7FFF_FFFF;

  typedef logic [1:0] branch_t;
  localparam branch_t BR_TRACE = 2'd0;
  localparam branch_t BR_M00   = 2'd1;
  localparam branch_t BR_M11   = 2'd2;
  localparam branch_t BR_M22   = 2'd3;

  typedef struct packed {
    branch_t                br;
    logic                   bad;
    logic [2:0]             neg;
    logic [2:0][MAG_W-1:0]  mag;
  } dcmq_meta_t;

  typedef struct packed {
    dcmq_meta_t        meta;
    logic [RAD_W-1:0]  rad;
  } dcmq_item_t;

  typedef struct packed {
    logic       full;
    logic       empty;
    logic [1:0] count;
  } dcmq_qstat_t;

endpackage

FILE: rtl/dcmq_front.sv
module dcmq_front #(
  parameter int FRAC_BITS = 30
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic signed [31:0]      in_m00,
  input  logic signed [31:0]      in_m01,
  input  logic signed [31:0]      in_m02,
  input  logic signed [31:0]      in_m10,
  input  logic signed [31:0]      in_m11,
  input  logic signed [31:0]      in_m12,
  input  logic signed [31:0]      in_m20,
  input  logic signed [31:0]      in_m21,
  input  logic signed [31:0]      in_m22,
  input  logic                    push_ok,
  output logic                    push,
  output dcmq_pkg::dcmq_item_t    item
);
  import dcmq_pkg::*;

  localparam logic signed [35:0] ONE = 36'sd1 <<< FRAC_BITS;

  logic              front_v_r;
  dcmq_item_t        item_r, item_nxt;
  logic signed [33:0] trace;
  logic signed [31:0] piv;
  logic signed [35:0] rad;
  branch_t           br;
  logic signed [32:0] n_a, n_b, n_c;
  logic signed [32:0] d12m, d20m, d01m, s01, s20, s12;
  logic              bad;

  assign trace = 34'(in_m00) + 34'(in_m11) + 34'(in_m22);

  // earlier candidate wins on ties
  always_comb begin
    br  = BR_TRACE;
    piv = '0;
    if (34'(in_m00) > trace) begin
      br  = BR_M00;
      piv = in_m00;
    end
    if (br == BR_TRACE ? (34'(in_m11) > trace) : (in_m11 > piv)) begin
      br  = BR_M11;
      piv = in_m11;
    end
    if (br == BR_TRACE ? (34'(in_m22) > trace) : (in_m22 > piv)) begin
      br  = BR_M22;
      piv = in_m22;
    end
  end

  assign rad = (br == BR_TRACE) ? ONE + 36'(trace)
                                : ONE + (36'(piv) <<< 1) - 36'(trace);
  assign bad = rad[35] || (rad == '0);

  assign d12m = 33'(in_m12) - 33'(in_m21);
  assign d20m = 33'(in_m20) - 33'(in_m02);
  assign d01m = 33'(in_m01) - 33'(in_m10);
  assign s01  = 33'(in_m01) + 33'(in_m10);
  assign s20  = 33'(in_m20) + 33'(in_m02);
  assign s12  = 33'(in_m12) + 33'(in_m21);

  always_comb begin
    unique case (br)
      BR_TRACE: begin n_a = d12m; n_b = d20m; n_c = d01m; end
      BR_M00:   begin n_a = d12m; n_b = s01;  n_c = s20;  end
      BR_M11:   begin n_a = d20m; n_b = s01;  n_c = s12;  end
      default:  begin n_a = d01m; n_b = s20;  n_c = s12;  end
    endcase
  end

  always_comb begin
    item_nxt.meta.br     = br;
    item_nxt.meta.bad    = bad;
    item_nxt.meta.neg    = {n_c[32], n_b[32], n_a[32]};
    item_nxt.meta.mag[0] = n_a[32] ? MAG_W'(-n_a) : MAG_W'(n_a);
    item_nxt.meta.mag[1] = n_b[32] ? MAG_W'(-n_b) : MAG_W'(n_b);
    item_nxt.meta.mag[2] = n_c[32] ? MAG_W'(-n_c) : MAG_W'(n_c);
    item_nxt.rad         = bad ? '0 : rad[RAD_W-1:0];
  end

  assign in_stall = front_v_r && !push_ok;
  assign push     = front_v_r && push_ok;
  assign item     = item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_v_r <= 1'b0;
    end else if (!in_stall) begin
      front_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      item_r <= item_nxt;
    end
  end

endmodule

FILE: rtl/dcmq_queue.sv
module dcmq_queue #(
  parameter int WIDTH = 8
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   push,
  input  logic [WIDTH-1:0]       wdata,
  input  logic                   pop,
  output logic [WIDTH-1:0]       rdata,
  output dcmq_pkg::dcmq_qstat_t  stat
);
  import dcmq_pkg::*;

  logic [WIDTH-1:0] mem_r [0:QDEPTH-1];
  logic             wr_ptr_r, rd_ptr_r;
  logic [1:0]       cnt_r, cnt_nxt;

  assign rdata      = mem_r[rd_ptr_r];
  assign stat.count = cnt_r;
  assign stat.full  = (cnt_r == 2'(QDEPTH));
  assign stat.empty = (cnt_r == 2'd0);

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) cnt_nxt = cnt_r + 2'd1;
    if (!push && pop) cnt_nxt = cnt_r - 2'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= ~wr_ptr_r;
      if (pop)  rd_ptr_r <= ~rd_ptr_r;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= wdata;
  end

endmodule

FILE: rtl/dcmq_back.sv
module dcmq_back #(
  parameter int FRAC_BITS = 30
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  head_valid,
  input  dcmq_pkg::dcmq_item_t  head,
  output logic                  pop,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic signed [31:0]    out_quat_w,
  output logic signed [31:0]    out_quat_x,
  output logic signed [31:0]    out_quat_y,
  output logic signed [31:0]    out_quat_z,
  output logic [1:0]            out_branch,
  output logic                  out_invalid
);
  import dcmq_pkg::*;

  logic adv;

  // square root pipeline
  logic              sq_v_r    [0:SQ_STEPS];
  logic [WIDE-1:0]   sq_rem_r  [0:SQ_STEPS];
  logic [ROOT_W-1:0] sq_root_r [0:SQ_STEPS];
  dcmq_meta_t        sq_meta_r [0:SQ_STEPS];

  // divider pipeline, three lanes sharing the pivot
  logic                  dv_v_r    [0:DV_STEPS];
  logic [2:0][WIDE-1:0]  dv_rem_r  [0:DV_STEPS];
  logic [2:0][ROOT_W-1:0] dv_q_r   [0:DV_STEPS];
  logic [2:0]            dv_ovf_r  [0:DV_STEPS];
  logic [ROOT_W-1:0]     dv_p_r    [0:DV_STEPS];
  dcmq_meta_t            dv_meta_r [0:DV_STEPS];

  logic              out_valid_r;
  logic [WORD-1:0]   qw_r, qx_r, qy_r, qz_r;
  branch_t           br_r;
  logic              inv_r;

  assign adv = !out_valid_r || !out_stall;
  assign pop = adv && head_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sq_v_r[0] <= 1'b0;
    end else if (adv) begin
      sq_v_r[0] <= head_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sq_rem_r[0]  <= WIDE'(head.rad) << (FRAC_BITS - 2);
      sq_root_r[0] <= '0;
      sq_meta_r[0] <= head.meta;
    end
  end

  for (genvar k = 0; k < SQ_STEPS; k++) begin : g_sq
    localparam int B = SQ_STEPS - 1 - k;
    logic [WIDE-1:0] trial;
    logic            ge;

    // rem = S - root^2; try setting bit B of the root
    assign trial = (WIDE'(sq_root_r[k]) << (B + 1)) + (WIDE'(1) << (2 * B));
    assign ge    = sq_rem_r[k] >= trial;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        sq_v_r[k+1] <= 1'b0;
      end else if (adv) begin
        sq_v_r[k+1] <= sq_v_r[k];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        sq_rem_r[k+1]  <= ge ? sq_rem_r[k] - trial : sq_rem_r[k];
        sq_root_r[k+1] <= ge ? (sq_root_r[k] | (ROOT_W'(1) << B)) : sq_root_r[k];
        sq_meta_r[k+1] <= sq_meta_r[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv_v_r[0] <= 1'b0;
    end else if (adv) begin
      dv_v_r[0] <= sq_v_r[SQ_STEPS];
    end
  end

  for (genvar j = 0; j < 3; j++) begin : g_dv0
    logic [WIDE-1:0] dvd;
    assign dvd = WIDE'(sq_meta_r[SQ_STEPS].mag[j]) << (FRAC_BITS - 2);

    // quotient saturates once it would need bit 31
    always_ff @(posedge clk) begin
      if (adv) begin
        dv_rem_r[0][j] <= dvd;
        dv_q_r[0][j]   <= '0;
        dv_ovf_r[0][j] <= dvd >= (WIDE'(sq_root_r[SQ_STEPS]) << ROOT_W);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dv_p_r[0]    <= sq_root_r[SQ_STEPS];
      dv_meta_r[0] <= sq_meta_r[SQ_STEPS];
    end
  end

  for (genvar k = 0; k < DV_STEPS; k++) begin : g_dv
    localparam int B = DV_STEPS - 1 - k;
    logic [WIDE-1:0] trial;

    assign trial = WIDE'(dv_p_r[k]) << B;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_v_r[k+1] <= 1'b0;
      end else if (adv) begin
        dv_v_r[k+1] <= dv_v_r[k];
      end
    end

    for (genvar j = 0; j < 3; j++) begin : g_lane
      logic take;
      assign take = !dv_ovf_r[k][j] && (dv_rem_r[k][j] >= trial);

      always_ff @(posedge clk) begin
        if (adv) begin
          dv_rem_r[k+1][j] <= take ? dv_rem_r[k][j] - trial : dv_rem_r[k][j];
          dv_q_r[k+1][j]   <= take ? (dv_q_r[k][j] | (ROOT_W'(1) << B)) : dv_q_r[k][j];
        end
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        dv_ovf_r[k+1]  <= dv_ovf_r[k];
        dv_p_r[k+1]    <= dv_p_r[k];
        dv_meta_r[k+1] <= dv_meta_r[k];
      end
    end
  end

  // sign, placement and final flip so w is not negative
  logic [2:0][WORD-1:0] sv;
  logic [WORD-1:0]      p32, w0, x0, y0, z0;
  logic [WORD-1:0]      qw_nxt, qx_nxt, qy_nxt, qz_nxt;
  dcmq_meta_t           fm;

  assign fm  = dv_meta_r[DV_STEPS];
  assign p32 = WORD'(dv_p_r[DV_STEPS]);

  for (genvar j = 0; j < 3; j++) begin : g_sign
    logic [WORD-1:0] mag;
    assign mag   = dv_ovf_r[DV_STEPS][j] ? SAT_MAX : WORD'(dv_q_r[DV_STEPS][j]);
    assign sv[j] = fm.neg[j] ? -mag : mag;
  end

  always_comb begin
    unique case (fm.br)
      BR_TRACE: begin w0 = p32;   x0 = sv[0]; y0 = sv[1]; z0 = sv[2]; end
      BR_M00:   begin w0 = sv[0]; x0 = p32;   y0 = sv[1]; z0 = sv[2]; end
      BR_M11:   begin w0 = sv[0]; x0 = sv[1]; y0 = p32;   z0 = sv[2]; end
      default:  begin w0 = sv[0]; x0 = sv[1]; y0 = sv[2]; z0 = p32;   end
    endcase
    if (fm.bad) begin
      qw_nxt = '0; qx_nxt = '0; qy_nxt = '0; qz_nxt = '0;
    end else if (w0[WORD-1]) begin
      qw_nxt = -w0; qx_nxt = -x0; qy_nxt = -y0; qz_nxt = -z0;
    end else begin
      qw_nxt = w0; qx_nxt = x0; qy_nxt = y0; qz_nxt = z0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= dv_v_r[DV_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      qw_r  <= qw_nxt;
      qx_r  <= qx_nxt;
      qy_r  <= qy_nxt;
      qz_r  <= qz_nxt;
      br_r  <= fm.br;
      inv_r <= fm.bad;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_quat_w  = qw_r;
  assign out_quat_x  = qx_r;
  assign out_quat_y  = qy_r;
  assign out_quat_z  = qz_r;
  assign out_branch  = br_r;
  assign out_invalid = inv_r;

endmodule

FILE: rtl/dcm_to_quaternion.sv
// Rotation matrix to quaternion converter.
// Input channel: nine signed matrix elements in_m00..in_m22 (FRAC_BITS fraction
// bits) with in_valid / in_stall; a transfer happens when valid is high and
// stall low. Output channel: out_quat_w..out_quat_z, out_branch (pivot used)
// and out_invalid, with out_valid / out_stall.
// One matrix is taken every cycle unless in_stall; results leave one per cycle,
// in order, unless out_stall holds them. With an idle queue an item passes the
// front register, queue slot, 32 stages of the bit-per-stage square root,
// 32 stages of the three-lane bit-per-stage divider and the output register.
// A stall on the output freezes the back pipeline; the two-entry queue and
// the front register keep taking items until they fill, then in_stall rises.
// Reset (synchronous, rst_n low) empties the pipeline and the queue; no
// result is pending afterwards.
// A radicand that is not positive gives out_invalid high and zero components.
module dcm_to_quaternion #(
  parameter int FRAC_BITS = 30
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [31:0] in_m00,
  input  logic signed [31:0] in_m01,
  input  logic signed [31:0] in_m02,
  input  logic signed [31:0] in_m10,
  input  logic signed [31:0] in_m11,
  input  logic signed [31:0] in_m12,
  input  logic signed [31:0] in_m20,
  input  logic signed [31:0] in_m21,
  input  logic signed [31:0] in_m22,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] out_quat_w,
  output logic signed [31:0] out_quat_x,
  output logic signed [31:0] out_quat_y,
  output logic signed [31:0] out_quat_z,
  output logic [1:0]         out_branch,
  output logic               out_invalid
);
  import dcmq_pkg::*;

  logic        push, push_ok, pop;
  dcmq_item_t  f_item, head;
  dcmq_qstat_t qstat;

  assign push_ok = !qstat.full || pop;

  dcmq_front #(.FRAC_BITS(FRAC_BITS)) u_front (
    .clk, .rst_n, .in_valid, .in_stall,
    .in_m00, .in_m01, .in_m02, .in_m10, .in_m11, .in_m12, .in_m20, .in_m21, .in_m22,
    .push_ok, .push, .item(f_item)
  );

  dcmq_queue #(.WIDTH($bits(dcmq_item_t))) u_queue (
    .clk, .rst_n, .push, .wdata(f_item), .pop, .rdata(head), .stat(qstat)
  );

  dcmq_back #(.FRAC_BITS(FRAC_BITS)) u_back (
    .clk, .rst_n, .head_valid(!qstat.empty), .head, .pop,
    .out_valid, .out_stall, .out_quat_w, .out_quat_x, .out_quat_y, .out_quat_z,
    .out_branch, .out_invalid
  );

  a_inv_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_invalid |->
      out_quat_w == 0 && out_quat_x == 0 && out_quat_y == 0 && out_quat_z == 0)
    else $error("invalid result carries non-zero components");

  a_w_nonneg: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !out_quat_w[31])
    else $error("negative scalar part");

  a_q_bound: assert property (@(posedge clk) disable iff (!rst_n)
    qstat.count <= 2'(QDEPTH))
    else $error("queue overfilled");

  a_q_stall: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> qstat.full)
    else $error("input stalled with queue space free");

endmodule
